// ===== design/elst_pkg.sv =====
package elst_pkg;

	localparam int NUM_TYPES = 32;
	localparam int TYPE_W = $clog2(NUM_TYPES);
	localparam int CNT_BITS = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_DUMP = 1'b1;

	localparam logic [2:0] ATTR_COUNT = 3'd0;
	localparam logic [2:0] ATTR_FAIL = 3'd1;
	localparam logic [2:0] ATTR_SUCC = 3'd2;
	localparam logic [2:0] ATTR_TIME = 3'd3;

	typedef struct packed {
		logic cmd;
		logic [4:0] stat_sel;
		logic [2:0] attr;
		logic [31:0] value;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] plain;
		logic [CNT_BITS-1:0] succ;
		logic [CNT_BITS-1:0] fail;
		logic [CNT_BITS-1:0] scnt;
		logic [CNT_BITS-1:0] ssum;
		logic [31:0] smax;
		logic [31:0] smin;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic entry_t entry_reset();
		entry_t e;
		e = '0;
		e.smin = '1;
		return e;
	endfunction

	function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] a,
			input logic [CNT_BITS-1:0] b);
		logic [CNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_BITS] ? '1 : s[CNT_BITS-1:0];
	endfunction

	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] a);
		return (&a) ? a : a + 1'b1;
	endfunction

endpackage

// ===== design/event_latency_stat_table_unit.sv =====
// Record transaction: the back end reads the entry, then updates and writes it.
// Dump transaction: dequeue, then a scan of each entry; a present entry goes on through read,
// a shift-subtract divide (only when it has samples) and emit.
// A two-entry queue takes new transactions while the back end works; busy = queue full.
// The receiver cannot stall. Reset (arst_n low, async) empties the queue and marks
// every entry absent; the table is cleared after each dump the same way.
module event_latency_stat_table_unit import elst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cmd,
	input logic [4:0] stat_sel,
	input logic [2:0] attr,
	input logic [31:0] value,
	output logic strobe,
	output logic [4:0] entry_type,
	output logic [31:0] count_shown,
	output logic [31:0] succ_total,
	output logic [31:0] fail_total,
	output logic [31:0] time_sum,
	output logic [31:0] time_avg,
	output logic [31:0] time_max,
	output logic [31:0] time_min,
	output logic last
);

	item_t item;
	head_t head;
	logic pop;

	assign item.cmd = cmd;
	assign item.stat_sel = stat_sel;
	assign item.attr = attr;
	assign item.value = value;

	elst_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.head(head),
		.pop(pop)
	);

	elst_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.strobe(strobe),
		.entry_type(entry_type),
		.count_shown(count_shown),
		.succ_total(succ_total),
		.fail_total(fail_total),
		.time_sum(time_sum),
		.time_avg(time_avg),
		.time_max(time_max),
		.time_min(time_min),
		.last(last)
	);

endmodule

// ===== design/elst_ram.sv =====
module elst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/elst_front.sv =====
module elst_front import elst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input item_t item,
	output head_t head,
	input logic pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0] count_q;
	logic push;

	assign busy = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign push = start && !busy;
	assign head.valid = (count_q != '0);
	assign head.item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

// ===== design/elst_div.sv =====
module elst_div import elst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [CNT_BITS-1:0] num,
	input logic [CNT_BITS-1:0] den,
	output logic done,
	output logic [CNT_BITS-1:0] quo
);

	localparam int SW = $clog2(CNT_BITS);

	logic [CNT_BITS-1:0] den_q, rem_q;
	logic [SW-1:0] step_q;
	logic run_q;
	logic [CNT_BITS:0] shifted;
	logic fits;

	assign shifted = {rem_q, quo[CNT_BITS-1]};
	assign fits = shifted >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (go) begin
			quo <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= fits ? CNT_BITS'(shifted - {1'b0, den_q}) : shifted[CNT_BITS-1:0];
			quo <= {quo[CNT_BITS-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				step_q <= SW'(CNT_BITS-1);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/elst_back.sv =====
module elst_back import elst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input head_t head,
	output logic pop,
	output logic strobe,
	output logic [4:0] entry_type,
	output logic [31:0] count_shown,
	output logic [31:0] succ_total,
	output logic [31:0] fail_total,
	output logic [31:0] time_sum,
	output logic [31:0] time_avg,
	output logic [31:0] time_max,
	output logic [31:0] time_min,
	output logic last
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_REC_WR, ST_SCAN, ST_DRD, ST_DIV, ST_EMIT
	} state_t;

	state_t state_q;
	logic [NUM_TYPES-1:0] present_q;
	logic [TYPE_W-1:0] idx_q;
	item_t cur_q;
	entry_t ent_q;
	logic last_q;

	logic [TYPE_W-1:0] raddr;
	logic [ENTRY_W-1:0] rdata;
	entry_t rd_ent, upd;
	logic we;
	logic more;
	logic div_go, div_done;
	logic [CNT_BITS-1:0] div_quo;

	elst_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_TYPES)) u_ram (
		.clk(clk),
		.we(we),
		.waddr(cur_q.stat_sel[TYPE_W-1:0]),
		.wdata(upd),
		.raddr(raddr),
		.rdata(rdata)
	);

	elst_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.num(rd_ent.ssum),
		.den(rd_ent.scnt),
		.done(div_done),
		.quo(div_quo)
	);

	assign pop = (state_q == ST_IDLE) && head.valid;
	assign we = (state_q == ST_REC_WR);
	assign raddr = (state_q == ST_IDLE) ? head.item.stat_sel[TYPE_W-1:0] : idx_q;
	assign div_go = (state_q == ST_DRD) && (rd_ent.scnt != '0);

	// an entry not marked present holds stale data: read it as cleared
	always_comb begin
		if (state_q == ST_REC_WR) begin
			rd_ent = present_q[cur_q.stat_sel[TYPE_W-1:0]] ? entry_t'(rdata) : entry_reset();
		end else begin
			rd_ent = entry_t'(rdata);
		end
	end

	always_comb begin
		upd = rd_ent;
		case (cur_q.attr)
			ATTR_COUNT: upd.plain = sat_inc(rd_ent.plain);
			ATTR_FAIL: upd.fail = sat_inc(rd_ent.fail);
			ATTR_SUCC: upd.succ = sat_inc(rd_ent.succ);
			ATTR_TIME: begin
				if (rd_ent.scnt == '0) begin
					upd.smax = cur_q.value;
					upd.smin = cur_q.value;
				end else begin
					if (cur_q.value > rd_ent.smax) upd.smax = cur_q.value;
					if (cur_q.value < rd_ent.smin) upd.smin = cur_q.value;
				end
				upd.scnt = sat_inc(rd_ent.scnt);
				upd.ssum = sat_add(rd_ent.ssum, CNT_BITS'(cur_q.value));
			end
			default: ;
		endcase
	end

	// any present entry above the current index
	always_comb begin
		more = 1'b0;
		for (int j = 0; j < NUM_TYPES; j++) begin
			if (TYPE_W'(j) > idx_q && present_q[j]) more = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			present_q <= '0;
			idx_q <= '0;
			strobe <= 1'b0;
			last_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						cur_q <= head.item;
						idx_q <= '0;
						state_q <= (head.item.cmd == CMD_DUMP) ? ST_SCAN : ST_REC_WR;
					end
				end
				ST_REC_WR: begin
					present_q[cur_q.stat_sel[TYPE_W-1:0]] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (present_q[idx_q]) begin
						state_q <= ST_DRD;
					end else if (idx_q == TYPE_W'(NUM_TYPES-1)) begin
						present_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRD: begin
					ent_q <= rd_ent;
					last_q <= !more;
					state_q <= (rd_ent.scnt != '0) ? ST_DIV : ST_EMIT;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe <= 1'b1;
					entry_type <= 5'(idx_q);
					count_shown <= (ent_q.plain != '0) ? ent_q.plain
						: sat_add(ent_q.succ, ent_q.fail);
					succ_total <= ent_q.succ;
					fail_total <= ent_q.fail;
					time_sum <= ent_q.ssum;
					if (ent_q.scnt != '0) begin
						time_avg <= div_quo;
						time_max <= ent_q.smax;
						time_min <= ent_q.smin;
					end else begin
						time_avg <= '0;
						time_max <= '0;
						time_min <= '0;
					end
					last <= last_q;
					if (last_q) begin
						present_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
